[rtl/core/gpm_pkg.sv]
// Shared definitions for the glob pattern matcher: operation codes, pattern
// characters, cell roles, the cell write and cell status structs, case folding.
// No dependencies.
package gpm_pkg;

    localparam int C_PATTERN_MAX = 32;
    localparam int C_POS_W       = 6;
    localparam int C_PTR_W       = 7;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_STAR  = 3'd1;
    localparam logic [2:0] K_ANY   = 3'd2;
    localparam logic [2:0] K_LIT   = 3'd3;
    localparam logic [2:0] K_SET   = 3'd4;
    localparam logic [2:0] K_ELEM  = 3'd5;
    localparam logic [2:0] K_RANGE = 3'd6;

    typedef struct packed {
        logic                 clr;
        logic                 we;
        logic [C_POS_W-1:0]   idx;
        logic [2:0]           kind;
        logic [7:0]           val;
        logic [7:0]           hi;
        logic [C_POS_W-1:0]   owner;
        logic [C_POS_W-1:0]   nxt;
        logic                 inv;
    } t_cell_wr;

    typedef struct packed {
        logic [2:0]           kind;
        logic [C_POS_W-1:0]   nxt;
        logic [C_POS_W-1:0]   owner;
        logic                 inv;
        logic                 lit_hit;
        logic                 elem_hit;
    } t_cell_out;

    function automatic logic [7:0] fold(input logic [7:0] x, input logic cs);
        logic [7:0] r;
        r = x;
        if (!cs && x >= CH_UPPER_A && x <= CH_UPPER_Z) begin
            r = x + 8'd32;
        end
        return r;
    endfunction

endpackage

[rtl/core/glob_pattern_matcher_top.sv]
// Top level of the glob pattern matcher: request handshake, pattern length and
// overflow, the active position set, the row of cells and the result stage.
// Depends on gpm_pkg, gpm_cell and gpm_decoder.

// Pattern bytes are taken one per cycle while o_in_stall is low. A text byte
// is first accepted and registered; then every cell compares it with its
// pattern position and the active set moves forward. The first text or end
// request after the pattern changed first waits for the decoder, which walks
// the pattern from the start and, for each opening bracket, scans ahead for
// the closing one before going back. Results are buffered two deep, so one
// waiting result does not hold up input; input stalls while both are full.
module glob_pattern_matcher_top import gpm_pkg::*; #(
    parameter int PATTERN_MAX = C_PATTERN_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    localparam int AW = $clog2(PATTERN_MAX);
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int NP = PATTERN_MAX + 1;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_DEC  = 2'd1;
    localparam logic [1:0] T_EXEC = 2'd2;

    logic [1:0]    r_st;
    logic          r_cs;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_dirty;
    logic [NP-1:0] r_act;
    logic [1:0]    r_op;
    logic [7:0]    r_d;
    logic          r_ov, r_om, r_oo;
    logic          r_hv, r_hm, r_ho;

    logic          acc_in;
    logic          dec_start;
    logic          dec_done;
    logic          app_we;
    t_cell_wr      wr;
    t_cell_out     co [PATTERN_MAX];
    logic [7:0]    fd;
    logic [NP-1:0] cl;
    logic [NP-1:0] n_act;
    logic [PATTERN_MAX-1:0] acc;
    logic [PATTERN_MAX-1:0] found;
    logic          is_text;
    logic          push;
    logic          res_m;
    logic          take;

    assign o_in_stall = (r_st != T_IDLE) || r_hv;
    assign acc_in     = i_in_valid && !o_in_stall;
    assign app_we     = acc_in && (i_operation == OP_APPEND) && (i_data_byte != 8'd0) &&
                        (r_len < LW'(PATTERN_MAX));
    assign dec_start  = acc_in && i_operation[1] && r_dirty;

    gpm_decoder #(.PATTERN_MAX(PATTERN_MAX)) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_app_we   (app_we),
        .i_app_addr (r_len[AW-1:0]),
        .i_app_data (i_data_byte),
        .i_len      (C_POS_W'(r_len)),
        .i_start    (dec_start),
        .o_done     (dec_done),
        .o_wr       (wr)
    );

    assign fd = fold(r_d, r_cs);

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        gpm_cell #(.CELL_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_fd    (fd),
            .i_cs    (r_cs),
            .o_st    (co[g])
        );
    end

    always_comb begin
        cl[0] = r_act[0];
        for (int k = 0; k < PATTERN_MAX; k++) begin
            cl[k+1] = r_act[k+1] || (cl[k] && (co[k].kind == K_STAR));
        end
        for (int s = 0; s < PATTERN_MAX; s++) begin
            found[s] = 1'b0;
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (co[j].elem_hit && (co[j].owner == C_POS_W'(s))) begin
                    found[s] = 1'b1;
                end
            end
            acc[s] = (co[s].kind == K_ANY) || ((co[s].kind == K_LIT) && co[s].lit_hit) ||
                     ((co[s].kind == K_SET) && (found[s] != co[s].inv));
        end
        for (int k = 0; k < NP; k++) begin
            n_act[k] = 1'b0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (cl[i] && (((co[i].kind == K_STAR) && (i == k)) ||
                              (acc[i] && (co[i].kind != K_STAR) &&
                               (co[i].nxt == C_POS_W'(k))))) begin
                    n_act[k] = 1'b1;
                end
            end
        end
    end

    assign is_text = (r_op == OP_TEXT) && (r_d != 8'd0);
    assign push    = (r_st == T_EXEC) && !is_text;
    assign res_m   = !r_ovf && cl[r_len];
    assign take    = r_ov && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= T_IDLE;
            r_cs    <= 1'b1;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_dirty <= 1'b1;
            r_act   <= NP'(1);
            r_ov    <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cs <= i_cfg_data;
            end
            unique case (r_st)
                T_IDLE: begin
                    if (acc_in) begin
                        unique case (i_operation)
                            OP_CLEAR: begin
                                r_len   <= '0;
                                r_ovf   <= 1'b0;
                                r_act   <= NP'(1);
                                r_dirty <= 1'b1;
                            end
                            OP_APPEND: begin
                                if (app_we) begin
                                    r_len <= r_len + 1'b1;
                                end else if (i_data_byte != 8'd0) begin
                                    r_ovf <= 1'b1;
                                end
                                r_act   <= NP'(1);
                                r_dirty <= 1'b1;
                            end
                            OP_TEXT, OP_END: begin
                                r_st <= r_dirty ? T_DEC : T_EXEC;
                            end
                        endcase
                    end
                end
                T_DEC: begin
                    if (dec_done) begin
                        r_dirty <= 1'b0;
                        r_st    <= T_EXEC;
                    end
                end
                T_EXEC: begin
                    r_act <= is_text ? n_act : NP'(1);
                    r_st  <= T_IDLE;
                end
                default: begin
                    r_st <= T_IDLE;
                end
            endcase
            if (r_hv) begin
                if (take) begin
                    r_hv <= 1'b0;
                end
            end else if (push) begin
                if (r_ov && !take) begin
                    r_hv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end else if (take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_op <= i_operation;
            r_d  <= i_data_byte;
        end
        if (r_hv) begin
            if (take) begin
                r_om <= r_hm;
                r_oo <= r_ho;
            end
        end else if (push) begin
            if (r_ov && !take) begin
                r_hm <= res_m;
                r_ho <= r_ovf;
            end else begin
                r_om <= res_m;
                r_oo <= r_ovf;
            end
        end
    end

    assign o_out_valid        = r_ov;
    assign o_matched          = r_om;
    assign o_pattern_overflow = r_oo;

endmodule

[rtl/core/gpm_cell.sv]
// One pattern position of the matcher: holds the decoded role of its byte and
// compares the current text byte against it.
// Depends on gpm_pkg.
module gpm_cell import gpm_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_wr  i_wr,
    input  logic [7:0] i_fd,
    input  logic      i_cs,
    output t_cell_out o_st
);

    logic [2:0]         r_kind;
    logic [7:0]         r_val;
    logic [7:0]         r_hi;
    logic [C_POS_W-1:0] r_owner;
    logic [C_POS_W-1:0] r_nxt;
    logic               r_inv;
    logic               sel;
    logic [7:0]         f_lo;
    logic [7:0]         f_hi;

    assign sel = i_wr.we && (i_wr.idx == C_POS_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            r_kind <= K_NONE;
        end else if (sel) begin
            r_kind <= i_wr.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_val   <= i_wr.val;
            r_hi    <= i_wr.hi;
            r_owner <= i_wr.owner;
            r_nxt   <= i_wr.nxt;
            r_inv   <= i_wr.inv;
        end
    end

    assign f_lo = fold(r_val, i_cs);
    assign f_hi = fold(r_hi, i_cs);

    always_comb begin
        o_st.kind     = r_kind;
        o_st.nxt      = r_nxt;
        o_st.owner    = r_owner;
        o_st.inv      = r_inv;
        o_st.lit_hit  = (f_lo == i_fd);
        o_st.elem_hit = ((r_kind == K_ELEM) && (f_lo == i_fd)) ||
                        ((r_kind == K_RANGE) && ($signed(i_fd) >= $signed(f_lo)) &&
                         ($signed(i_fd) <= $signed(f_hi)));
    end

endmodule

[rtl/core/gpm_decoder.sv]
// Pattern byte store and the sequencer that walks the token chain from the
// start of the pattern and writes each position's role into the cells.
// Depends on gpm_pkg.
module gpm_decoder import gpm_pkg::*; #(
    parameter int PATTERN_MAX = C_PATTERN_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_app_we,
    input  logic [$clog2(PATTERN_MAX)-1:0] i_app_addr,
    input  logic [7:0]                     i_app_data,
    input  logic [C_POS_W-1:0]             i_len,
    input  logic                           i_start,
    output logic                           o_done,
    output t_cell_wr                       o_wr
);

    localparam int AW = $clog2(PATTERN_MAX);

    localparam logic [3:0] D_IDLE = 4'd0;
    localparam logic [3:0] D_TOK  = 4'd1;
    localparam logic [3:0] D_ESC  = 4'd2;
    localparam logic [3:0] D_FC0  = 4'd3;
    localparam logic [3:0] D_FC1  = 4'd4;
    localparam logic [3:0] D_FC2  = 4'd5;
    localparam logic [3:0] D_SET0 = 4'd6;
    localparam logic [3:0] D_E0   = 4'd7;
    localparam logic [3:0] D_E0B  = 4'd8;
    localparam logic [3:0] D_E1   = 4'd9;
    localparam logic [3:0] D_E2   = 4'd10;
    localparam logic [3:0] D_E3   = 4'd11;
    localparam logic [3:0] D_E4   = 4'd12;

    logic [7:0]         r_mem [PATTERN_MAX];
    logic [7:0]         r_rd;
    logic [3:0]         r_st, n_st;
    logic [C_PTR_W-1:0] r_ptr, n_ptr;
    logic [C_PTR_W-1:0] r_p, n_p;
    logic [C_POS_W-1:0] r_s, n_s;
    logic [C_POS_W-1:0] r_close, n_close;
    logic [C_POS_W-1:0] r_e, n_e;
    logic [7:0]         r_lo, n_lo;
    logic               r_inv, n_inv;
    logic [C_PTR_W-1:0] len_x;
    logic [C_PTR_W-1:0] close_x;
    logic [7:0]         b;
    logic               fin;
    logic [C_PTR_W-1:0] fin_p;

    always_ff @(posedge i_clk) begin
        if (i_app_we) begin
            r_mem[i_app_addr] <= i_app_data;
        end
        r_rd <= r_mem[n_ptr[AW-1:0]];
    end

    assign len_x   = C_PTR_W'(i_len);
    assign close_x = C_PTR_W'(r_close);
    assign b       = (r_ptr < len_x) ? r_rd : 8'd0;

    always_comb begin
        n_st    = r_st;
        n_ptr   = r_ptr;
        n_p     = r_p;
        n_s     = r_s;
        n_close = r_close;
        n_e     = r_e;
        n_lo    = r_lo;
        n_inv   = r_inv;
        fin     = 1'b0;
        fin_p   = r_ptr;
        o_done  = 1'b0;
        o_wr    = '0;
        unique case (r_st)
            D_IDLE: begin
                n_ptr = '0;
                if (i_start) begin
                    o_wr.clr = 1'b1;
                    n_st     = D_TOK;
                end
            end
            D_TOK: begin
                o_wr.idx = r_ptr[C_POS_W-1:0];
                o_wr.nxt = C_POS_W'(r_ptr + 1'b1);
                n_s      = r_ptr[C_POS_W-1:0];
                if (r_ptr >= len_x) begin
                    o_done = 1'b1;
                    n_ptr  = '0;
                    n_st   = D_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    priority if (b == CH_STAR) begin
                        o_wr.we   = 1'b1;
                        o_wr.kind = K_STAR;
                    end else if (b == CH_QUEST) begin
                        o_wr.we   = 1'b1;
                        o_wr.kind = K_ANY;
                    end else if (b == CH_BSLASH) begin
                        if (r_ptr + 1'b1 < len_x) begin
                            n_st = D_ESC;
                        end else begin
                            o_wr.we   = 1'b1;
                            o_wr.kind = K_LIT;
                            o_wr.val  = CH_BSLASH;
                        end
                    end else if (b == CH_LBRK) begin
                        n_st = D_FC0;
                    end else begin
                        o_wr.we   = 1'b1;
                        o_wr.kind = K_LIT;
                        o_wr.val  = b;
                    end
                end
            end
            D_ESC: begin
                o_wr.we   = 1'b1;
                o_wr.idx  = r_s;
                o_wr.kind = K_LIT;
                o_wr.val  = b;
                o_wr.nxt  = r_s + 2'd2;
                n_ptr     = r_ptr + 1'b1;
                n_st      = D_TOK;
            end
            D_FC0: begin
                if (b == CH_BANG) begin
                    n_ptr = r_ptr + 1'b1;
                end
                n_st = D_FC1;
            end
            D_FC1: begin
                if (r_ptr >= len_x) begin
                    o_wr.we   = 1'b1;
                    o_wr.idx  = r_s;
                    o_wr.kind = K_LIT;
                    o_wr.val  = CH_LBRK;
                    o_wr.nxt  = r_s + 1'b1;
                    n_ptr     = C_PTR_W'(r_s) + 1'b1;
                    n_st      = D_TOK;
                end else begin
                    n_ptr = (b == CH_BSLASH) ? r_ptr + 2'd2 : r_ptr + 1'b1;
                    n_st  = D_FC2;
                end
            end
            D_FC2: begin
                if (r_ptr < len_x && b == CH_RBRK) begin
                    n_close = r_ptr[C_POS_W-1:0];
                    n_ptr   = C_PTR_W'(r_s) + 1'b1;
                    n_st    = D_SET0;
                end else begin
                    n_st = D_FC1;
                end
            end
            D_SET0: begin
                n_inv     = (b == CH_BANG);
                o_wr.we   = 1'b1;
                o_wr.idx  = r_s;
                o_wr.kind = K_SET;
                o_wr.inv  = (b == CH_BANG);
                o_wr.nxt  = r_close + 1'b1;
                n_ptr     = (b == CH_BANG) ? r_ptr + 1'b1 : r_ptr;
                n_st      = D_E0;
            end
            D_E0: begin
                n_e   = r_ptr[C_POS_W-1:0];
                n_ptr = r_ptr + 1'b1;
                if (b == CH_BSLASH) begin
                    n_st = D_E0B;
                end else begin
                    n_lo = b;
                    n_st = D_E1;
                end
            end
            D_E0B: begin
                n_lo  = b;
                n_ptr = r_ptr + 1'b1;
                n_st  = D_E1;
            end
            D_E1: begin
                if (b == CH_DASH) begin
                    n_p   = r_ptr;
                    n_ptr = r_ptr + 1'b1;
                    n_st  = D_E2;
                end else begin
                    o_wr.we = 1'b1;
                    o_wr.kind = K_ELEM;
                    fin   = 1'b1;
                    fin_p = r_ptr;
                end
            end
            D_E2: begin
                if (b != CH_RBRK) begin
                    n_st = D_E3;
                end else begin
                    o_wr.we   = 1'b1;
                    o_wr.kind = K_ELEM;
                    fin   = 1'b1;
                    fin_p = r_p;
                end
            end
            D_E3: begin
                n_ptr = r_ptr + 1'b1;
                if (b == CH_BSLASH) begin
                    n_st = D_E4;
                end else begin
                    o_wr.we   = 1'b1;
                    o_wr.kind = K_RANGE;
                    o_wr.hi   = b;
                    fin   = 1'b1;
                    fin_p = r_ptr + 1'b1;
                end
            end
            D_E4: begin
                o_wr.we   = 1'b1;
                o_wr.kind = K_RANGE;
                o_wr.hi   = b;
                fin   = 1'b1;
                fin_p = r_ptr + 1'b1;
            end
            default: begin
                n_st = D_IDLE;
            end
        endcase
        if (r_st >= D_E1) begin
            o_wr.idx   = r_e;
            o_wr.val   = r_lo;
            o_wr.owner = r_s;
        end
        if (fin) begin
            if (fin_p < close_x) begin
                n_ptr = fin_p;
                n_st  = D_E0;
            end else begin
                n_ptr = close_x + 1'b1;
                n_st  = D_TOK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= D_IDLE;
            r_ptr <= '0;
        end else begin
            r_st  <= n_st;
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_s     <= n_s;
        r_close <= n_close;
        r_e     <= n_e;
        r_lo    <= n_lo;
        r_inv   <= n_inv;
    end

endmodule

[rtl/core/gpm_checker.sv]
// Port-level checks for the glob pattern matcher, bound to the top level.
// Depends on gpm_pkg.
module gpm_checker import gpm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_operation,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_matched,
    input logic       o_pattern_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_ovf_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_matched && o_pattern_overflow))
        else $error("overflowed pattern reported a match");

    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_TEXT || i_operation == OP_END)
        |=> o_in_stall)
        else $error("text request not given its compare cycle");

    a_setup_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_CLEAR || i_operation == OP_APPEND)
        |=> !o_out_valid || $past(o_out_valid))
        else $error("pattern request produced a result");

endmodule

bind glob_pattern_matcher_top gpm_checker u_gpm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_operation        (i_operation),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_matched          (o_matched),
    .o_pattern_overflow (o_pattern_overflow)
);
